// ===== rtl/core/mp2d_pkg.sv =====
// Shared types and constants for the streaming 2-D max pooling block
`default_nettype none
package mp2d_pkg;

  localparam int POS_W       = 9;   // map positions and window indices
  localparam int SLOT_W      = 4;   // line store row slot (up to 16 rows)
  localparam int CFG_W       = 9;   // widest configuration register
  localparam int RESULT_CAP  = 64;  // most results caused by one sample
  localparam int CAP_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               map_start;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pooled;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic               last;
  } result_t;

  // Clamped configuration as the datapath sees it
  typedef struct packed {
    logic [4:0] k;
    logic [3:0] s;
    pos_t       w;
    pos_t       h;
  } cfg_t;

  // One classified sample handed from the front to the back
  typedef struct packed {
    logic signed [15:0] sample;
    pos_t               r;
    pos_t               c;
    pos_t               rq;
    pos_t               cq;
    logic [SLOT_W-1:0]  slot;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/mp2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mp2d_fifo.sv =====
// Short job queue between the front and back parts
`default_nettype none
module mp2d_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mp2d_pkg::job_t din,
  output logic               full,
  input  wire logic          pop,
  output mp2d_pkg::job_t     dout,
  output logic               empty
);

  localparam int PW = (mp2d_pkg::QUEUE_DEPTH > 1) ? $clog2(mp2d_pkg::QUEUE_DEPTH) : 1;

  mp2d_pkg::job_t        entries [mp2d_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wp;
  logic [PW-1:0]         rp;
  logic [PW:0]           cnt;

  assign full  = (cnt == (PW+1)'(mp2d_pkg::QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign dout  = entries[rp];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(mp2d_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(mp2d_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mp2d_front.sv =====
// Front part: accepts samples, tracks map position and queues classified jobs
`default_nettype none
module mp2d_front #(
  parameter int MAX_KERNEL = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mp2d_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire mp2d_pkg::item_t item,
  input  wire logic            full,
  output logic                 push,
  output mp2d_pkg::job_t       job
);

  mp2d_pkg::pos_t                row_pos, col_pos, rq, cq;
  logic [3:0]                    rrem, crem;
  logic [mp2d_pkg::SLOT_W-1:0]   slot;

  logic                          restart;
  mp2d_pkg::pos_t                cur_r, cur_c, cur_rq, cur_cq, c1, r1;
  logic [3:0]                    cur_rrem, cur_crem;
  logic [mp2d_pkg::SLOT_W-1:0]   cur_slot;

  assign item_ready = !full;
  assign push       = item_valid && !full;

  // Start over at the origin on map start or a stale position
  always_comb begin
    restart  = item.map_start || (row_pos >= cfg.h) || (col_pos >= cfg.w);
    cur_r    = restart ? '0 : row_pos;
    cur_c    = restart ? '0 : col_pos;
    cur_rq   = restart ? '0 : rq;
    cur_cq   = restart ? '0 : cq;
    cur_rrem = restart ? '0 : rrem;
    cur_crem = restart ? '0 : crem;
    cur_slot = restart ? '0 : slot;
    c1       = cur_c + 1'b1;
    r1       = cur_r + 1'b1;
    job.sample = item.sample;
    job.r      = cur_r;
    job.c      = cur_c;
    job.rq     = cur_rq;
    job.cq     = cur_cq;
    job.slot   = cur_slot;
  end

  // Advance raster position with running quotients by the stride
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      rq      <= '0;
      cq      <= '0;
      rrem    <= '0;
      crem    <= '0;
      slot    <= '0;
    end else if (push) begin
      if (c1 >= cfg.w) begin
        col_pos <= '0;
        cq      <= '0;
        crem    <= '0;
        if (r1 >= cfg.h) begin
          row_pos <= '0;
          rq      <= '0;
          rrem    <= '0;
          slot    <= '0;
        end else begin
          row_pos <= r1;
          if (5'(cur_rrem) + 5'd1 >= 5'(cfg.s)) begin
            rq   <= cur_rq + 1'b1;
            rrem <= '0;
          end else begin
            rq   <= cur_rq;
            rrem <= cur_rrem + 1'b1;
          end
          slot <= (cur_slot == mp2d_pkg::SLOT_W'(MAX_KERNEL - 1)) ? '0 : cur_slot + 1'b1;
        end
      end else begin
        col_pos <= c1;
        row_pos <= cur_r;
        rq      <= cur_rq;
        rrem    <= cur_rrem;
        slot    <= cur_slot;
        if (5'(cur_crem) + 5'd1 >= 5'(cfg.s)) begin
          cq   <= cur_cq + 1'b1;
          crem <= '0;
        end else begin
          cq   <= cur_cq;
          crem <= cur_crem + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mp2d_back.sv =====
// Back part: stores samples, finds finished windows and scans their maxima
`default_nettype none
module mp2d_back #(
  parameter int MAX_KERNEL = 8,
  parameter int MAX_WIDTH  = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mp2d_pkg::cfg_t    cfg,
  input  wire logic              empty,
  input  wire mp2d_pkg::job_t    job,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output mp2d_pkg::result_t      result
);

  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    IDLE, FIND_I, FIND_J, CHECK, SCAN, DRAIN, EMIT, FINISH
  } state_t;

  state_t                          state;
  mp2d_pkg::job_t                  it;
  mp2d_pkg::pos_t                  ci, cj, jlo, rr, cc, cc0;
  logic [mp2d_pkg::SLOT_W-1:0]     slot_cur;
  logic signed [15:0]              best;
  logic                            first;
  logic                            rd_v;
  logic [mp2d_pkg::CAP_W-1:0]      cnt;
  mp2d_pkg::result_t               pend;
  logic                            pend_v;
  mp2d_pkg::result_t               out_r;
  logic                            out_v;

  logic [13:0]                     prod_i, prod_j, e_i, e_j, ce_i, ce_j;
  logic                            i_back, j_back, row_ok, col_ok, win_ok;
  logic                            more_i, more_j, out_free, out_load;
  logic [3:0]                      d4;
  logic [mp2d_pkg::SLOT_W-1:0]     slot0;
  logic [AW-1:0]                   waddr, raddr;
  logic [15:0]                     rdata;
  mp2d_pkg::result_t               nr;
  mp2d_pkg::result_t               pend_last;

  // Window bounds for the current candidate origin
  always_comb begin
    prod_i   = 14'(ci) * 14'(cfg.s);
    prod_j   = 14'(cj) * 14'(cfg.s);
    i_back   = (ci != '0) &&
               (prod_i - 14'(cfg.s) + 14'(cfg.k) - 14'd1 >= 14'(it.r));
    j_back   = (cj != '0) &&
               (prod_j - 14'(cfg.s) + 14'(cfg.k) - 14'd1 >= 14'(it.c));
    e_i      = prod_i + 14'(cfg.k) - 14'd1;
    e_j      = prod_j + 14'(cfg.k) - 14'd1;
    ce_i     = (e_i < 14'(cfg.h) - 14'd1) ? e_i : 14'(cfg.h) - 14'd1;
    ce_j     = (e_j < 14'(cfg.w) - 14'd1) ? e_j : 14'(cfg.w) - 14'd1;
    row_ok   = (prod_i + 14'(cfg.s) <= 14'(cfg.h)) && (ce_i == 14'(it.r));
    col_ok   = (prod_j + 14'(cfg.s) <= 14'(cfg.w)) && (ce_j == 14'(it.c));
    win_ok   = row_ok && col_ok && (cnt < mp2d_pkg::CAP_W'(mp2d_pkg::RESULT_CAP));
    d4       = 4'(it.r - prod_i[mp2d_pkg::POS_W-1:0]);
    slot0    = (it.slot >= d4) ? it.slot - d4 :
               mp2d_pkg::SLOT_W'(5'(it.slot) + 5'(MAX_KERNEL) - 5'(d4));
    more_i   = (ci != it.rq);
    more_j   = (cj != it.cq);
    out_free = !out_v || result_ready;
    out_load = pend_v && out_free && ((state == EMIT) || (state == FINISH));
    waddr    = AW'(job.slot * MAX_WIDTH) + AW'(job.c);
    raddr    = AW'(slot_cur * MAX_WIDTH) + AW'(cc);
    nr.pooled  = best;
    nr.out_row = ci[7:0];
    nr.out_col = cj[7:0];
    nr.last    = 1'b0;
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  assign pop          = (state == IDLE) && !empty;
  assign result_valid = out_v;
  assign result       = out_r;

  mp2d_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (pop),
    .waddr (waddr),
    .wdata (job.sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer, accumulator and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      pend_v <= 1'b0;
      out_v  <= 1'b0;
      rd_v   <= 1'b0;
      first  <= 1'b0;
      cnt    <= '0;
    end else begin
      // reload the output register from the pending slot, or drop it on a transfer
      if (out_load) begin
        out_v <= 1'b1;
      end else if (out_v && result_ready) begin
        out_v <= 1'b0;
      end
      rd_v <= (state == SCAN);
      // fold returning store data into the running maximum
      if (rd_v) begin
        if (first || ($signed(rdata) > best)) begin
          best <= $signed(rdata);
        end
        first <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (!empty) begin
            it    <= job;
            ci    <= job.rq;
            cnt   <= '0;
            state <= FIND_I;
          end
        end
        FIND_I: begin
          if (i_back) begin
            ci <= ci - 1'b1;
          end else begin
            cj    <= it.cq;
            state <= FIND_J;
          end
        end
        FIND_J: begin
          if (j_back) begin
            cj <= cj - 1'b1;
          end else begin
            jlo   <= cj;
            state <= CHECK;
          end
        end
        CHECK: begin
          if (win_ok) begin
            rr       <= prod_i[mp2d_pkg::POS_W-1:0];
            cc       <= prod_j[mp2d_pkg::POS_W-1:0];
            cc0      <= prod_j[mp2d_pkg::POS_W-1:0];
            slot_cur <= slot0;
            first    <= 1'b1;
            state    <= SCAN;
          end else if (more_j) begin
            cj <= cj + 1'b1;
          end else if (more_i) begin
            ci <= ci + 1'b1;
            cj <= jlo;
          end else begin
            state <= FINISH;
          end
        end
        SCAN: begin
          if (cc == it.c) begin
            cc <= cc0;
            rr <= rr + 1'b1;
            slot_cur <= (slot_cur == mp2d_pkg::SLOT_W'(MAX_KERNEL - 1)) ?
                        '0 : slot_cur + 1'b1;
            if (rr == it.r) begin
              state <= DRAIN;
            end
          end else begin
            cc <= cc + 1'b1;
          end
        end
        DRAIN: begin
          state <= EMIT;
        end
        EMIT: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              out_r <= pend;
            end
            pend   <= nr;
            pend_v <= 1'b1;
            cnt    <= cnt + 1'b1;
            if (more_j) begin
              cj    <= cj + 1'b1;
              state <= CHECK;
            end else if (more_i) begin
              ci    <= ci + 1'b1;
              cj    <= jlo;
              state <= CHECK;
            end else begin
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (!pend_v) begin
            state <= IDLE;
          end else if (out_free) begin
            out_r  <= pend_last;
            pend_v <= 1'b0;
            state  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !pend_v)
    else $error("pending result left over between samples");

  a_scan_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (rr <= it.r))
    else $error("window scan ran past the current row");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= mp2d_pkg::CAP_W'(mp2d_pkg::RESULT_CAP))
    else $error("more results than the cap for one sample");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT && pend_v && !out_free) |=> (state == EMIT))
    else $error("result dropped while output stalled");

endmodule
`default_nettype wire

// ===== rtl/core/max_pool_2d_stream.sv =====
// Top level of the streaming 2-D max pooling block
//
//   channel   signals                            width  role
//   item      item_valid / item_ready / item     17     sample and map start in
//   result    result_valid / result_ready / result 33   window maximum out
//   config    cfg_we / cfg_index / cfg_data      2+9    register writes
//
// A sample enters through the job queue; the back part then stores it, steps back to find
// the first row and column window, and for each candidate window runs a check plus, if it
// finishes here, rows*cols store reads, a drain and an emit step, then a closing step; the
// single store read port sets the cost of the reads.
// Reset is synchronous; the line store is not cleared.
// A stalled result holds in the output register while one more is kept pending.
`default_nettype none
module max_pool_2d_stream #(
  parameter int MAX_KERNEL = 8,
  parameter int MAX_WIDTH  = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire mp2d_pkg::item_t               item,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output mp2d_pkg::result_t                  result,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [mp2d_pkg::CFG_W-1:0]    cfg_data
);

  logic [3:0]      kernel_size, stride;
  logic [8:0]      map_width, map_height;
  mp2d_pkg::cfg_t  cfg;
  logic            full, push, empty, pop;
  mp2d_pkg::job_t  job_in, job_out;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= 4'd2;
      stride      <= 4'd2;
      map_width   <= 9'd32;
      map_height  <= 9'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        mp2d_pkg::REG_KERNEL: kernel_size <= cfg_data[3:0];
        mp2d_pkg::REG_STRIDE: stride      <= cfg_data[3:0];
        mp2d_pkg::REG_WIDTH:  map_width   <= cfg_data;
        mp2d_pkg::REG_HEIGHT: map_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp configuration into its working range
  always_comb begin
    cfg.k = (kernel_size == '0) ? 5'd1 :
            (5'(kernel_size) > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : 5'(kernel_size);
    cfg.s = (stride == '0) ? 4'd1 : stride;
    cfg.w = (map_width == '0) ? 9'd1 :
            (32'(map_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : map_width;
    cfg.h = (map_height == '0) ? 9'd1 :
            (map_height > 9'd256) ? 9'd256 : map_height;
  end

  mp2d_front #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .full       (full),
    .push       (push),
    .job        (job_in)
  );

  mp2d_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (pop),
    .dout  (job_out),
    .empty (empty)
  );

  mp2d_back #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .job          (job_out),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== tb/max_pool_2d_stream_tb.sv =====
// Testbench for max_pool_2d_stream: random maps checked against a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module max_pool_2d_stream_tb;

  // Window maxima expected from accepted samples, worked out from the pooling rules
  class pool_board;
    logic [8:0] kernel_reg, stride_reg, width_reg, height_reg;
    logic signed [15:0] line_mem [0:2047];
    int unsigned row_at, col_at;
    mp2d_pkg::result_t pending_max[$];
    int errors;

    function new();
      kernel_reg = 9'd2;
      stride_reg = 9'd2;
      width_reg = 9'd32;
      height_reg = 9'd32;
      row_at = 0;
      col_at = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        mp2d_pkg::REG_KERNEL: kernel_reg = val & 9'hF;
        mp2d_pkg::REG_STRIDE: stride_reg = val & 9'hF;
        mp2d_pkg::REG_WIDTH:  width_reg = val;
        mp2d_pkg::REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned origin_lo(int unsigned pos, int unsigned k, int unsigned s);
      if (pos + 1 <= k) return 0;
      return (pos + 1 - k + s - 1) / s;
    endfunction

    function int unsigned clip_end(int unsigned idx, int unsigned k, int unsigned s,
                                   int unsigned lim);
      int unsigned e;
      e = idx * s + k - 1;
      return (e < lim - 1) ? e : lim - 1;
    endfunction

    // Store the sample and queue every window that it completes
    function void note_item(mp2d_pkg::item_t it);
      int unsigned k, s, w, h, r, c, oh, ow, ilo, ihi, jlo, jhi;
      logic signed [15:0] best, v;
      mp2d_pkg::result_t res;
      mp2d_pkg::result_t found[$];
      k = (kernel_reg == 0) ? 1 : (kernel_reg > 8) ? 8 : kernel_reg;
      s = (stride_reg == 0) ? 1 : stride_reg;
      w = (width_reg == 0) ? 1 : (width_reg > 256) ? 256 : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > 256) ? 256 : height_reg;
      r = row_at;
      c = col_at;
      if (it.map_start || r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      line_mem[(r % 8) * 256 + c] = it.sample;
      oh = h / s;
      ow = w / s;
      if (oh > 0 && ow > 0) begin
        ilo = origin_lo(r, k, s);
        ihi = r / s;
        if (ihi > oh - 1) ihi = oh - 1;
        jlo = origin_lo(c, k, s);
        jhi = c / s;
        if (jhi > ow - 1) jhi = ow - 1;
        for (int unsigned i = ilo; i <= ihi; i++) begin
          if (clip_end(i, k, s, h) != r) continue;
          for (int unsigned j = jlo; j <= jhi; j++) begin
            if (clip_end(j, k, s, w) != c) continue;
            if (found.size() >= mp2d_pkg::RESULT_CAP) continue;
            best = line_mem[((i * s) % 8) * 256 + ((j * s) % 256)];
            for (int unsigned rr = i * s; rr <= r; rr++)
              for (int unsigned cc = j * s; cc <= c; cc++) begin
                v = line_mem[(rr % 8) * 256 + (cc % 256)];
                if (v > best) best = v;
              end
            res.pooled = best;
            res.out_row = i[7:0];
            res.out_col = j[7:0];
            res.last = 1'b0;
            found.push_back(res);
          end
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[n]) pending_max.push_back(found[n]);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_at = r;
      col_at = c;
    endfunction

    function void check_result(mp2d_pkg::result_t got);
      mp2d_pkg::result_t want;
      if (pending_max.size() == 0) begin
        $display("%0t: unexpected result pooled=%0d row=%0d col=%0d last=%0b", $time,
                 got.pooled, got.out_row, got.out_col, got.last);
        errors++;
        return;
      end
      want = pending_max.pop_front();
      if (got.pooled !== want.pooled || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last !== want.last) begin
        $display("%0t: mismatch expected pooled=%0d row=%0d col=%0d last=%0b", $time,
                 want.pooled, want.out_row, want.out_col, want.last);
        $display("%0t:          actual   pooled=%0d row=%0d col=%0d last=%0b", $time,
                 got.pooled, got.out_row, got.out_col, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  mp2d_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  mp2d_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = mp2d_pkg::REG_KERNEL;
  logic [mp2d_pkg::CFG_W-1:0] cfg_data = '0;

  pool_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  max_pool_2d_stream u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver: stall at random, check each transfer
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_result(result);
  end

  // Hold the sample until transferred; called at a falling edge
  task automatic send_sample(logic signed [15:0] val, logic start);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item.sample <= val;
    item.map_start <= start;
    do @(posedge clk); while (!item_ready);
    board.note_item('{sample: val, map_start: start});
    sent++;
    @(negedge clk);
  endtask

  // Wait for every expected window, then let trailing work finish
  task automatic drain();
    item_valid <= 1'b0;
    while (board.pending_max.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Present one register write for a cycle; the caller drops the enable
  task automatic write_cfg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_shape(logic [8:0] k, logic [8:0] s, logic [8:0] w, logic [8:0] h);
    drain();
    write_cfg(mp2d_pkg::REG_KERNEL, k);
    write_cfg(mp2d_pkg::REG_STRIDE, s);
    write_cfg(mp2d_pkg::REG_WIDTH, w);
    write_cfg(mp2d_pkg::REG_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // One map with random content; a few early restarts as noise
  task automatic run_map(int count);
    for (int n = 0; n < count; n++)
      send_sample(rand_sample(), (n == 0) || ($urandom_range(99) < 2));
  endtask

  initial begin
    int k, s, w, h;
    int maps;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme samples, then alternating 0 and -1 in a 4x4 map, waiting out each result set of the latter
    set_shape(2, 2, 4, 4);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    for (int n = 0; n < 12; n++) begin
      send_sample((n % 2) ? 16'shFFFF : 16'sh0000, 1'b0);
      drain();
    end
    // Zero registers act as 1: a 1x1 map wraps without map_start
    set_shape(0, 0, 0, 0);
    send_sample(16'sh1234, 1'b1);
    send_sample(16'shEDCB, 1'b0);
    // Shrink the map in mid-map: next sample lands at the origin
    set_shape(2, 2, 4, 4);
    for (int n = 0; n < 6; n++) send_sample(rand_sample(), n == 0);
    set_shape(2, 1, 2, 2);
    for (int n = 0; n < 4; n++) send_sample(rand_sample(), 1'b0);

    // Random maps over all idling phases, a few extreme shapes among them
    maps = 0;
    while (sent < 280 || maps < 8) begin
      case (maps % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      case (maps)
        2: begin k = 12; s = 5; w = 11; h = 5; end
        4: begin k = 8; s = 1; w = 9; h = 9; end
        6: begin k = 9; s = 1; w = 1; h = 1; end
        7: begin k = 3; s = 2; w = 2; h = 12; end
        default: begin
          k = $urandom_range(15);
          s = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 3);
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 10);
        end
      endcase
      set_shape(9'(k), 9'(s), 9'(w), 9'(h));
      w = (w > 256) ? 256 : w;
      run_map(($urandom_range(9) == 0) ? $urandom_range(1, w * h) : w * h);
      maps++;
    end

    drain();
    if (board.errors == 0) $display("max_pool_2d_stream_tb passed");
    else $display("max_pool_2d_stream_tb failed");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("max_pool_2d_stream_tb failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/mp2d_pkg.sv
rtl/core/mp2d_ram.sv
rtl/core/mp2d_fifo.sv
rtl/core/mp2d_front.sv
rtl/core/mp2d_back.sv
rtl/core/max_pool_2d_stream.sv
tb/max_pool_2d_stream_tb.sv
